@@ hdl/ars_pkg.sv @@
`default_nettype none
package ars_pkg;

	localparam int DEF_NUM_ENTRIES = 16;
	localparam int DEF_NUM_PHASES  = 3;

	localparam int WEIGHT_W = 24;
	localparam int TOTAL_W  = 28;
	localparam int SUM_W    = 32;
	localparam int COUNT_W  = 16;
	localparam int EIU_W    = 5;
	localparam int EPS_W    = 17;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 24'h010000;
	localparam logic [EPS_W-1:0]    EPS_ONE    = 17'h10000;
	localparam logic [EIU_W-1:0]    EIU_RESET  = 5'd16;
	localparam logic [EPS_W-1:0]    EPS_RESET  = 17'h08000;
	localparam logic [15:0]         ROUND_HALF = 16'h8000;

	// configuration register indexes
	localparam logic CFG_IDX_ENTRIES   = 1'b0;
	localparam logic CFG_IDX_SMOOTHING = 1'b1;

	// request kinds
	localparam logic [1:0] REQ_SELECT = 2'd0;
	localparam logic [1:0] REQ_RECORD = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_SELECTED = 2'd0;
	localparam logic [1:0] ST_RECORDED = 2'd1;
	localparam logic [1:0] ST_UPDATED  = 2'd2;
	localparam logic [1:0] ST_BAD      = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  phase;
		logic [15:0] random_fraction;
		logic [3:0]  entry_index;
		logic [23:0] score_value;
	} req_t;

	typedef struct packed {
		logic [3:0]  chosen_index;
		logic [27:0] phase_weight_total;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_DISPATCH,
		OP_TOT_INIT,
		OP_TOT_RD,
		OP_TOT_ACC,
		OP_SEL_MUL,
		OP_WALK,
		OP_REC_RD,
		OP_REC_WR,
		OP_UPD_RD,
		OP_UPD_CHK,
		OP_DIV,
		OP_MUL1,
		OP_MUL2,
		OP_UPD_WR,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   take;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       phase_ok;
		logic       idx_ok;
		logic       hit;
		logic       walk_last;
		logic       cnt_zero;
		logic       div_last;
		logic       upd_last;
		logic       tot_e_last;
		logic       tot_p_last;
		logic       out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/ars_ram.sv @@
`default_nettype none
module ars_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

@@ hdl/ars_ctrl.sv @@
`default_nettype none
module ars_ctrl
	import ars_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      req_valid,
	input  wire      cfg_valid,
	input  wire      cfg_index,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     req_stall,
	output logic     cfg_ready
);

	typedef enum logic [4:0] {
		S_TOT_INIT,
		S_TOT_RD,
		S_TOT_ACC,
		S_IDLE,
		S_DISPATCH,
		S_SEL_MUL,
		S_WALK,
		S_REC_RD,
		S_REC_WR,
		S_UPD_RD,
		S_UPD_CHK,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_UPD_WR,
		S_DONE
	} state_t;

	state_t state_q;
	logic   upd_q;
	logic   recompute;

	assign cfg_ready = (state_q == S_IDLE);
	assign recompute = cfg_valid && cfg_ready && (cfg_index == CFG_IDX_ENTRIES);
	assign req_stall = (state_q != S_IDLE) || (cfg_valid && (cfg_index == CFG_IDX_ENTRIES));

	always_comb begin
		cmd.take = req_valid && !req_stall;
		unique case (state_q)
			S_TOT_INIT: cmd.op = OP_TOT_INIT;
			S_TOT_RD:   cmd.op = OP_TOT_RD;
			S_TOT_ACC:  cmd.op = OP_TOT_ACC;
			S_IDLE:     cmd.op = OP_NOP;
			S_DISPATCH: cmd.op = OP_DISPATCH;
			S_SEL_MUL:  cmd.op = OP_SEL_MUL;
			S_WALK:     cmd.op = OP_WALK;
			S_REC_RD:   cmd.op = OP_REC_RD;
			S_REC_WR:   cmd.op = OP_REC_WR;
			S_UPD_RD:   cmd.op = OP_UPD_RD;
			S_UPD_CHK:  cmd.op = OP_UPD_CHK;
			S_DIV:      cmd.op = OP_DIV;
			S_MUL1:     cmd.op = OP_MUL1;
			S_MUL2:     cmd.op = OP_MUL2;
			S_UPD_WR:   cmd.op = OP_UPD_WR;
			S_DONE:     cmd.op = stat.out_free ? OP_RESULT : OP_NOP;
			default:    cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TOT_INIT;
			upd_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_TOT_INIT: state_q <= S_TOT_RD;
				S_TOT_RD:   state_q <= S_TOT_ACC;
				S_TOT_ACC: begin
					if (stat.tot_e_last && stat.tot_p_last) begin
						state_q <= upd_q ? S_DONE : S_IDLE;
					end else begin
						state_q <= S_TOT_RD;
					end
				end
				S_IDLE: begin
					if (recompute) begin
						upd_q   <= 1'b0;
						state_q <= S_TOT_INIT;
					end else if (cmd.take) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (stat.req == REQ_SELECT && stat.phase_ok) begin
						state_q <= S_SEL_MUL;
					end else if (stat.req == REQ_RECORD && stat.phase_ok && stat.idx_ok) begin
						state_q <= S_REC_RD;
					end else if (stat.req == REQ_UPDATE) begin
						state_q <= S_UPD_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SEL_MUL: state_q <= S_WALK;
				S_WALK: begin
					if (stat.hit || stat.walk_last) begin
						state_q <= S_DONE;
					end
				end
				S_REC_RD:  state_q <= S_REC_WR;
				S_REC_WR:  state_q <= S_DONE;
				S_UPD_RD:  state_q <= S_UPD_CHK;
				S_UPD_CHK: state_q <= stat.cnt_zero ? S_UPD_WR : S_DIV;
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_UPD_WR;
				S_UPD_WR: begin
					if (stat.upd_last) begin
						upd_q   <= 1'b1;
						state_q <= S_TOT_INIT;
					end else begin
						state_q <= S_UPD_RD;
					end
				end
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/ars_dp.sv @@
`default_nettype none
module ars_dp
	import ars_pkg::*;
#(
	parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
	parameter int NUM_PHASES  = DEF_NUM_PHASES
) (
	input  wire              clk,
	input  wire              arst_n,
	input  ctl_cmd_t         cmd,
	output dp_stat_t         stat,
	input  req_t             req_data,
	input  wire              rsp_stall,
	output logic             rsp_valid,
	output rsp_t             rsp_data,
	input  wire              cfg_wr,
	input  wire              cfg_index,
	input  wire [EPS_W-1:0]  cfg_data
);

	localparam int DEPTH = NUM_PHASES * NUM_ENTRIES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int PW    = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
	localparam int NW    = $clog2(NUM_ENTRIES + 1);
	localparam int SC_W  = SUM_W + COUNT_W;

	req_t                item_q;
	logic [EIU_W-1:0]    eiu_q;
	logic [EPS_W-1:0]    eps_cfg_q;
	logic [EW-1:0]       e_q;
	logic [PW-1:0]       p_q;
	logic [AW-1:0]       a_q;
	logic [TOTAL_W-1:0]  sel_q;
	logic [TOTAL_W-1:0]  acc_q;
	logic [TOTAL_W-1:0]  tot_q [NUM_PHASES];
	logic [3:0]          chosen_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]    quo_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [4:0]          dcnt_q;
	logic [40:0]         p1_q;
	logic [40:0]         p2_q;
	logic [DEPTH-1:0]    wvld_q;
	logic [DEPTH-1:0]    scvld_q;
	logic                wvld_rd_q;
	logic                scvld_rd_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [NW-1:0]       n_act;
	logic [EPS_W-1:0]    eps;
	logic                phase_ok;
	logic                idx_ok;
	logic [AW-1:0]       ibase;
	logic [AW-1:0]       pbase;
	logic [AW-1:0]       ram_addr;
	logic [WEIGHT_W-1:0] w_raw;
	logic [SC_W-1:0]     sc_raw;
	logic [WEIGHT_W-1:0] w_rd;
	logic [SC_W-1:0]     sc_rd;
	logic [SUM_W-1:0]    sum_rd;
	logic [COUNT_W-1:0]  cnt_rd;
	logic                w_we;
	logic                sc_we;
	logic [SC_W-1:0]     sc_wdata;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    sum_new;
	logic [COUNT_W-1:0]  cnt_new;
	logic [41:0]         mix;
	logic [WEIGHT_W-1:0] w_new;
	logic [WEIGHT_W-1:0] mean_sat;
	logic [EPS_W-1:0]    mul_a;
	logic [TOTAL_W-1:0]  mul_b;
	logic [44:0]         prod;
	logic [TOTAL_W-1:0]  tot_sel;
	logic [TOTAL_W:0]    acc_sum;
	logic [TOTAL_W-1:0]  acc_new;
	logic                walk_last;
	logic [COUNT_W:0]    div_r;
	logic                div_ge;
	logic                out_free;
	rsp_t                rsp_new;

	// active entry count, clamped to 1..NUM_ENTRIES
	always_comb begin
		if (eiu_q == '0) begin
			n_act = NW'(1);
		end else if (32'(eiu_q) > 32'(NUM_ENTRIES)) begin
			n_act = NW'(NUM_ENTRIES);
		end else begin
			n_act = NW'(eiu_q);
		end
	end

	assign eps      = (eps_cfg_q > EPS_ONE) ? EPS_ONE : eps_cfg_q;
	assign phase_ok = 32'(item_q.phase) < 32'(NUM_PHASES);
	assign idx_ok   = 32'(item_q.entry_index) < 32'(n_act);
	assign ibase    = AW'(item_q.phase) * AW'(NUM_ENTRIES);
	assign pbase    = AW'(p_q) * AW'(NUM_ENTRIES);
	assign walk_last = NW'(e_q) == (n_act - NW'(1));
	assign tot_sel  = phase_ok ? tot_q[PW'(item_q.phase)] : '0;

	always_comb begin
		case (cmd.op) inside
			OP_SEL_MUL:           ram_addr = ibase + AW'(e_q);
			OP_WALK:              ram_addr = ibase + AW'(walk_last ? e_q : e_q + 1'b1);
			OP_REC_RD, OP_REC_WR: ram_addr = ibase + AW'(item_q.entry_index);
			OP_TOT_RD, OP_TOT_ACC: ram_addr = pbase + AW'(e_q);
			default:              ram_addr = a_q;
		endcase
	end

	// entries never written read as their reset values
	assign w_rd   = wvld_rd_q ? w_raw : WEIGHT_ONE;
	assign sc_rd  = scvld_rd_q ? sc_raw : '0;
	assign sum_rd = sc_rd[SC_W-1:COUNT_W];
	assign cnt_rd = sc_rd[COUNT_W-1:0];

	assign sum_add = {1'b0, sum_rd} + (SUM_W+1)'(item_q.score_value);
	assign sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	assign cnt_new = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

	assign mean_sat = (|quo_q[SUM_W-1:WEIGHT_W]) ? '1 : quo_q[WEIGHT_W-1:0];
	assign mix      = 42'(p1_q) + 42'(p2_q) + 42'(ROUND_HALF);
	assign w_new    = (|mix[41:40]) ? '1 : mix[39:16];

	assign w_we     = (cmd.op == OP_UPD_WR) && (cnt_q != '0);
	assign sc_we    = (cmd.op == OP_REC_WR) || (cmd.op == OP_UPD_WR);
	assign sc_wdata = (cmd.op == OP_REC_WR) ? {sum_new, cnt_new} : '0;

	always_comb begin
		case (cmd.op)
			OP_SEL_MUL: begin
				mul_a = EPS_W'(item_q.random_fraction);
				mul_b = tot_sel;
			end
			OP_MUL1: begin
				mul_a = eps;
				mul_b = TOTAL_W'(mean_sat);
			end
			default: begin
				mul_a = EPS_ONE - eps;
				mul_b = TOTAL_W'(w_q);
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign acc_sum = {1'b0, acc_q} + (TOTAL_W+1)'(w_rd);
	assign acc_new = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];

	assign div_r  = {rem_q, quo_q[SUM_W-1]};
	assign div_ge = div_r >= {1'b0, cnt_q};

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		rsp_new = '0;
		rsp_new.status = ST_BAD;
		case (item_q.req_type)
			REQ_SELECT: begin
				if (phase_ok) begin
					rsp_new.chosen_index       = chosen_q;
					rsp_new.phase_weight_total = tot_sel;
					rsp_new.status             = ST_SELECTED;
				end
			end
			REQ_RECORD: begin
				if (phase_ok) begin
					rsp_new.phase_weight_total = tot_sel;
					if (idx_ok) begin
						rsp_new.status = ST_RECORDED;
					end
				end
			end
			REQ_UPDATE: begin
				rsp_new.phase_weight_total = tot_sel;
				rsp_new.status             = ST_UPDATED;
			end
			default: rsp_new.status = ST_BAD;
		endcase
	end

	ars_ram #(.WIDTH(WEIGHT_W), .DEPTH(DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.addr  (ram_addr),
		.wdata (w_new),
		.rdata (w_raw)
	);

	ars_ram #(.WIDTH(SC_W), .DEPTH(DEPTH)) u_score_ram (
		.clk   (clk),
		.we    (sc_we),
		.addr  (ram_addr),
		.wdata (sc_wdata),
		.rdata (sc_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q       <= EIU_RESET;
			eps_cfg_q   <= EPS_RESET;
			wvld_q      <= '0;
			scvld_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (cfg_index == CFG_IDX_ENTRIES) begin
					eiu_q <= cfg_data[EIU_W-1:0];
				end else begin
					eps_cfg_q <= cfg_data;
				end
			end
			if (w_we) begin
				wvld_q[ram_addr] <= 1'b1;
			end
			if (sc_we) begin
				scvld_q[ram_addr] <= 1'b1;
			end
			if (cmd.op == OP_RESULT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wvld_rd_q  <= wvld_q[ram_addr];
		scvld_rd_q <= scvld_q[ram_addr];
		if (cmd.take) begin
			item_q <= req_data;
		end
		case (cmd.op)
			OP_DISPATCH: begin
				e_q      <= '0;
				a_q      <= '0;
				chosen_q <= '0;
			end
			OP_TOT_INIT: begin
				p_q   <= '0;
				e_q   <= '0;
				acc_q <= '0;
			end
			OP_TOT_ACC: begin
				if (walk_last) begin
					tot_q[p_q] <= acc_new;
					acc_q      <= '0;
					e_q        <= '0;
					p_q        <= p_q + 1'b1;
				end else begin
					acc_q <= acc_new;
					e_q   <= e_q + 1'b1;
				end
			end
			OP_SEL_MUL: sel_q <= prod[43:16];
			OP_WALK: begin
				if (sel_q < TOTAL_W'(w_rd)) begin
					chosen_q <= 4'(e_q);
				end else begin
					sel_q <= sel_q - TOTAL_W'(w_rd);
					e_q   <= e_q + 1'b1;
				end
			end
			OP_UPD_CHK: begin
				w_q    <= w_rd;
				cnt_q  <= cnt_rd;
				quo_q  <= sum_rd;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			OP_DIV: begin
				rem_q  <= div_ge ? COUNT_W'(div_r - {1'b0, cnt_q}) : div_r[COUNT_W-1:0];
				quo_q  <= {quo_q[SUM_W-2:0], div_ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
			OP_MUL1:   p1_q  <= prod[40:0];
			OP_MUL2:   p2_q  <= prod[40:0];
			OP_UPD_WR: a_q   <= a_q + 1'b1;
			OP_RESULT: rsp_q <= rsp_new;
			default: ;
		endcase
	end

	assign stat.req        = item_q.req_type;
	assign stat.phase_ok   = phase_ok;
	assign stat.idx_ok     = idx_ok;
	assign stat.hit        = sel_q < TOTAL_W'(w_rd);
	assign stat.walk_last  = walk_last;
	assign stat.cnt_zero   = (cnt_rd == '0);
	assign stat.div_last   = (dcnt_q == 5'd31);
	assign stat.upd_last   = (a_q == AW'(DEPTH - 1));
	assign stat.tot_e_last = walk_last;
	assign stat.tot_p_last = (p_q == PW'(NUM_PHASES - 1));
	assign stat.out_free   = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WALK |-> 32'(e_q) < 32'(n_act))
		else $error("walk beyond active entries");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESULT |-> out_free)
		else $error("result overwrites pending transaction");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DIV |-> cnt_q != '0)
		else $error("division by zero count");

	a_update_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_UPD_WR |-> 32'(a_q) < 32'(DEPTH))
		else $error("update sweep address out of range");

endmodule
`default_nettype wire

@@ hdl/adaptive_roulette_selector_unit.sv @@
// Select walks the weights of the entries in use until a hit; record is a read-modify-write;
//   bad phase, index or kind goes straight to the result; update sweeps all
//   NUM_PHASES*NUM_ENTRIES entries, dividing and mixing each counted one, then a totals sweep.
// One transaction at a time: requests stall until the last result is registered;
//   the select walk and the 32-step divider are serial.
// Reset: asynchronous; weights 1.0, scores zero; a totals sweep runs first.
`default_nettype none
module adaptive_roulette_selector_unit
	import ars_pkg::*;
#(
	parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
	parameter int NUM_PHASES  = DEF_NUM_PHASES
) (
	input  wire             clk,
	input  wire             arst_n,
	// request channel
	input  wire             req_valid,
	output logic            req_stall,
	input  req_t            req_data,
	// result channel
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output rsp_t            rsp_data,
	// configuration writes: index 0 entries in use, 1 smoothing factor
	input  wire             cfg_valid,
	output logic            cfg_ready,
	input  wire             cfg_index,
	input  wire [EPS_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// controller: sequences select walk, record read-modify-write,
	// update sweep with divider and multiplier steps, and totals sweep
	ars_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall),
		.cfg_ready (cfg_ready)
	);

	// datapath: weight and score memories, shared multiplier, serial divider,
	// totals, result register decoupling the result transaction
	ars_dp #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.NUM_PHASES  (NUM_PHASES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

@@ tb/adaptive_roulette_selector_unit_tb.sv @@
`default_nettype none
module adaptive_roulette_selector_unit_tb;
	import ars_pkg::*;

	localparam int N_ENT = DEF_NUM_ENTRIES;
	localparam int N_PH  = DEF_NUM_PHASES;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req_data;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic             cfg_index;
	logic [EPS_W-1:0] cfg_data;

	// shadow of the selector state, kept in step with every accepted transaction
	logic [WEIGHT_W-1:0] shadow_weight [N_PH][N_ENT];
	logic [SUM_W-1:0]    shadow_score  [N_PH][N_ENT];
	logic [COUNT_W-1:0]  shadow_uses   [N_PH][N_ENT];
	logic [TOTAL_W-1:0]  shadow_total  [N_PH];
	logic [EIU_W-1:0]    shadow_eiu;
	logic [EPS_W-1:0]    shadow_eps;

	rsp_t pending_rsp[$];
	int   mismatches;
	int   send_idle_pct;
	int   recv_stall_pct;

	adaptive_roulette_selector_unit uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	function automatic int methods_active();
		if (shadow_eiu < 1) return 1;
		if (shadow_eiu > N_ENT) return N_ENT;
		return int'(shadow_eiu);
	endfunction

	// totals cover only the methods in use, saturating at 28 bits
	function automatic void refresh_totals();
		longint unsigned acc;
		for (int p = 0; p < N_PH; p++) begin
			acc = 0;
			for (int e = 0; e < methods_active(); e++) acc += shadow_weight[p][e];
			shadow_total[p] = (acc > 64'hFFFFFFF) ? 28'hFFFFFFF : acc[TOTAL_W-1:0];
		end
	endfunction

	function automatic void shadow_reset();
		shadow_eiu = EIU_RESET;
		shadow_eps = EPS_RESET;
		for (int p = 0; p < N_PH; p++)
			for (int e = 0; e < N_ENT; e++) begin
				shadow_weight[p][e] = WEIGHT_ONE;
				shadow_score[p][e]  = '0;
				shadow_uses[p][e]   = '0;
			end
		refresh_totals();
	endfunction

	// smoothing pass: every counted weight moves toward its mean score
	function automatic void smooth_all();
		longint unsigned eps, mean, mix;
		eps = (shadow_eps > EPS_ONE) ? 64'd65536 : 64'(shadow_eps);
		for (int p = 0; p < N_PH; p++)
			for (int e = 0; e < N_ENT; e++) begin
				if (shadow_uses[p][e] != 0) begin
					mean = shadow_score[p][e] / shadow_uses[p][e];
					if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
					mix = eps * mean + (64'd65536 - eps) * shadow_weight[p][e] + 64'd32768;
					mix = mix >> 16;
					shadow_weight[p][e] = (mix > 64'hFFFFFF) ? 24'hFFFFFF : mix[23:0];
				end
				shadow_score[p][e] = '0;
				shadow_uses[p][e]  = '0;
			end
		refresh_totals();
	endfunction

	function automatic rsp_t roulette_predict(req_t rq);
		rsp_t r;
		logic phase_ok;
		longint unsigned sel, s;
		r = '{chosen_index: '0, phase_weight_total: '0, status: ST_BAD};
		phase_ok = rq.phase < N_PH;
		case (rq.req_type)
			REQ_SELECT: if (phase_ok) begin
				sel = (64'(rq.random_fraction) * shadow_total[rq.phase]) >> 16;
				for (int e = 0; e < methods_active(); e++) begin
					if (sel < shadow_weight[rq.phase][e]) begin
						r.chosen_index = e[3:0];
						break;
					end
					sel -= shadow_weight[rq.phase][e];
				end
				r.phase_weight_total = shadow_total[rq.phase];
				r.status = ST_SELECTED;
			end
			REQ_RECORD: if (phase_ok) begin
				r.phase_weight_total = shadow_total[rq.phase];
				if (rq.entry_index < methods_active()) begin
					s = 64'(shadow_score[rq.phase][rq.entry_index]) + rq.score_value;
					shadow_score[rq.phase][rq.entry_index] =
						(s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
					if (shadow_uses[rq.phase][rq.entry_index] != 16'hFFFF)
						shadow_uses[rq.phase][rq.entry_index]++;
					r.status = ST_RECORDED;
				end
			end
			REQ_UPDATE: begin
				smooth_all();
				r.phase_weight_total = phase_ok ? shadow_total[rq.phase] : '0;
				r.status = ST_UPDATED;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_data.chosen_index !== want.chosen_index)
					report_mismatch("chosen_index", int'(rsp_data.chosen_index),
						int'(want.chosen_index));
				if (rsp_data.phase_weight_total !== want.phase_weight_total)
					report_mismatch("phase_weight_total", int'(rsp_data.phase_weight_total),
						int'(want.phase_weight_total));
				if (rsp_data.status !== want.status)
					report_mismatch("status", int'(rsp_data.status), int'(want.status));
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// one request transaction; valid is left high so back-to-back sends need no dip
	task automatic send_request(req_t rq);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= rq;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp = {pending_rsp, roulette_predict(rq)};
	endtask

	task automatic send(logic [1:0] kind, logic [1:0] ph, logic [15:0] frac,
			logic [3:0] idx, logic [23:0] score);
		send_request('{req_type: kind, phase: ph, random_fraction: frac,
			entry_index: idx, score_value: score});
	endtask

	// drop valid and let all outstanding transactions drain before touching registers
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [EPS_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_IDX_ENTRIES) begin
			shadow_eiu = val[EIU_W-1:0];
			refresh_totals();
		end else begin
			shadow_eps = val;
		end
	endtask

	task automatic test_select_extremes();
		for (int p = 0; p < 4; p++) begin
			send(REQ_SELECT, p[1:0], 16'h0000, 4'h0, 24'h0);
			send(REQ_SELECT, p[1:0], 16'hFFFF, 4'hF, 24'hFFFFFF);
		end
		send(REQ_SELECT, 2'd0, 16'h8000, 4'h0, 24'h0);
	endtask

	task automatic test_record_and_update();
		send(REQ_RECORD, 2'd0, 16'h0, 4'd0, 24'hFFFFFF);
		send(REQ_RECORD, 2'd0, 16'h0, 4'd15, 24'h000000);
		send(REQ_RECORD, 2'd2, 16'hFFFF, 4'd7, 24'h030000);
		send(REQ_RECORD, 2'd3, 16'h0, 4'd1, 24'h010000);   // bad phase
		send(REQ_UPDATE, 2'd0, 16'h0, 4'd0, 24'h0);
		send(REQ_SELECT, 2'd0, 16'hFFFF, 4'd0, 24'h0);
		send(REQ_RECORD, 2'd1, 16'h0, 4'd3, 24'h020000);
		send(REQ_UPDATE, 2'd3, 16'h0, 4'd0, 24'h0);          // update, bad phase
	endtask

	task automatic test_unused_kind();
		send(REQ_UNUSED, 2'd0, 16'h1234, 4'd2, 24'h0);
		send(REQ_UNUSED, 2'd3, 16'hFFFF, 4'hF, 24'hFFFFFF);
	endtask

	// entries_in_use of 0 and 31 exercise the clamp; a small pool makes bad indexes
	task automatic test_register_extremes();
		write_reg(CFG_IDX_ENTRIES, 17'd0);
		send(REQ_RECORD, 2'd0, 16'h0, 4'd1, 24'h1);         // bad index
		send(REQ_SELECT, 2'd0, 16'hFFFF, 4'd0, 24'h0);
		write_reg(CFG_IDX_ENTRIES, 17'd31);
		send(REQ_SELECT, 2'd1, 16'hC000, 4'd0, 24'h0);
		write_reg(CFG_IDX_SMOOTHING, 17'h1FFFF);
		send(REQ_RECORD, 2'd1, 16'h0, 4'd4, 24'hFFFFFF);
		send(REQ_UPDATE, 2'd1, 16'h0, 4'd0, 24'h0);
		write_reg(CFG_IDX_SMOOTHING, 17'd0);
		send(REQ_RECORD, 2'd1, 16'h0, 4'd5, 24'h0);
		send(REQ_UPDATE, 2'd1, 16'h0, 4'd0, 24'h0);
		write_reg(CFG_IDX_SMOOTHING, EPS_ONE);
		write_reg(CFG_IDX_ENTRIES, 17'd5);
		send(REQ_RECORD, 2'd2, 16'h0, 4'd5, 24'h1);         // first unused index
		send(REQ_RECORD, 2'd2, 16'h0, 4'd4, 24'h40000);
		send(REQ_UPDATE, 2'd2, 16'h0, 4'd0, 24'h0);
		write_reg(CFG_IDX_ENTRIES, 17'd16);
	endtask

	// 260 maximal scores push one sum past 32 bits
	task automatic test_score_saturation();
		for (int i = 0; i < 260; i++) send(REQ_RECORD, 2'd1, 16'h0, 4'd2, 24'hFFFFFF);
		send(REQ_UPDATE, 2'd1, 16'h0, 4'd0, 24'h0);
		send(REQ_SELECT, 2'd1, 16'h2000, 4'd0, 24'h0);
	endtask

	task automatic test_random(int count);
		int k;
		logic [1:0] ph;
		for (int i = 0; i < count; i++) begin
			if (i % 250 == 249) begin
				write_reg(CFG_IDX_ENTRIES, 17'($urandom_range(31)));
				write_reg(CFG_IDX_SMOOTHING, 17'($urandom_range(131071)));
			end
			k  = $urandom_range(99);
			ph = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(N_PH - 1));
			if (k < 50)
				send(REQ_SELECT, ph, 16'($urandom), 4'($urandom), 24'($urandom));
			else if (k < 92)
				send(REQ_RECORD, ph, 16'($urandom), 4'($urandom), 24'($urandom));
			else if (k < 97)
				send(REQ_UPDATE, ph, 16'($urandom), 4'($urandom), 24'($urandom));
			else
				send(REQ_UNUSED, ph, 16'($urandom), 4'($urandom), 24'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		shadow_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_select_extremes();
		test_record_and_update();
		test_unused_kind();
		test_register_extremes();
		test_score_saturation();

		send_idle_pct = 9;  recv_stall_pct = 47;
		test_random(450);
		send_idle_pct = 47; recv_stall_pct = 9;
		test_random(450);
		send_idle_pct = 0;  recv_stall_pct = 0;
		test_random(450);

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#200000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/ars_pkg.sv
hdl/ars_ram.sv
hdl/ars_ctrl.sv
hdl/ars_dp.sv
hdl/adaptive_roulette_selector_unit.sv
tb/adaptive_roulette_selector_unit_tb.sv
